// ----- hw/rtl/ffa_pkg.sv -----
`timescale 1ns / 1ps

package ffa_pkg;

    // default geometry of the map
    localparam int DEF_NUM_BLOCKS  = 64;
    localparam int DEF_BLOCK_BYTES = 16;

    // wide enough for any block index or count up to 1024 blocks
    localparam int WAVE_W = 11;

    // field widths
    localparam int BYTES_W   = 11;
    localparam int ADDR_W    = 10;
    localparam int RUNS_W    = 6;
    localparam int BLOCKS_W  = 7;

    // request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_NOFIT = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [BYTES_W-1:0] request_bytes;
        logic [ADDR_W-1:0]  region_address;
    } t_ffa_req;

    typedef struct packed {
        logic                status;
        logic [ADDR_W-1:0]   granted_address;
        logic [RUNS_W-1:0]   free_runs;
        logic [BLOCKS_W-1:0] free_blocks;
    } t_ffa_rsp;

    // record that walks down the row of cells, one cell per cycle
    typedef struct packed {
        logic              valid;
        logic              upd;        // 0 search pass, 1 update and count pass
        logic              set_val;    // value written into cells inside [lo, hi)
        logic              found;
        logic              prev_free;
        logic [WAVE_W-1:0] need;
        logic [WAVE_W-1:0] run_len;
        logic [WAVE_W-1:0] run_start;
        logic [WAVE_W-1:0] lo;
        logic [WAVE_W-1:0] hi;
        logic [WAVE_W-1:0] runs;
        logic [WAVE_W-1:0] blocks;
    } t_ffa_wave;

endpackage

// ----- hw/rtl/ffa_cell.sv -----
`timescale 1ns / 1ps

module ffa_cell
    import ffa_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ffa_wave i_wave,
    output t_ffa_wave o_wave
);

    localparam logic [WAVE_W-1:0] K = WAVE_W'(CELL_IDX);

    logic      r_used;
    logic      n_used;
    t_ffa_wave r_wave;
    t_ffa_wave n_wave;
    logic      w_free;

    always_comb begin
        n_wave = i_wave;
        n_used = r_used;
        w_free = 1'b0;
        if (i_wave.valid) begin
            if (i_wave.upd) begin
                if ((K >= i_wave.lo) && (K < i_wave.hi)) begin
                    n_used = i_wave.set_val;
                end
                w_free = !n_used;
                if (w_free) begin
                    n_wave.blocks = i_wave.blocks + WAVE_W'(1);
                    if (!i_wave.prev_free) begin
                        n_wave.runs = i_wave.runs + WAVE_W'(1);
                    end
                end
                n_wave.prev_free = w_free;
            end else if (!i_wave.found) begin
                if (!r_used) begin
                    if (i_wave.run_len == '0) begin
                        n_wave.run_start = K;
                    end
                    n_wave.run_len = i_wave.run_len + WAVE_W'(1);
                    if (n_wave.run_len == i_wave.need) begin
                        n_wave.found = 1'b1;
                    end
                end else begin
                    n_wave.run_len = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= 1'b0;
            r_wave.valid <= 1'b0;
        end else begin
            r_used <= n_used;
            r_wave <= n_wave;
        end
    end

    assign o_wave = r_wave;

endmodule

// ----- hw/rtl/first_fit_bitmap_block_allocator_core.sv -----
`timescale 1ns / 1ps

// First-fit bitmap block allocator. The map holds NUM_BLOCKS blocks of
// BLOCK_BYTES bytes, one block per cell in a row of cells, all free after
// reset. An allocate request asks for request_bytes / BLOCK_BYTES blocks
// and gets the lowest free run of that length, marked used, with its byte
// address; a request under one block or with no fitting run reports
// status 1 and leaves the map alone. A free request clears the blocks from
// region_address / BLOCK_BYTES up to (region_address + request_bytes) /
// BLOCK_BYTES minus one, clamped at the end of the map. Every result also
// carries the number of maximal free runs and free blocks after the
// operation. One request is handled at a time. A record walks down the row
// one cell per cycle: an allocate takes a search walk and then an update
// walk, a free takes the update walk only. The result sits in an output
// register, and the next request is taken while it still waits for its
// transfer out.

module first_fit_bitmap_block_allocator_core
    import ffa_pkg::*;
#(
    parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS,
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    // request channel
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_ffa_req i_in_req,
    // result channel
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_ffa_rsp o_out_rsp
);

    localparam int SUM_W  = BYTES_W + 1;
    localparam int PROD_W = WAVE_W + 13;
    localparam logic [SUM_W-1:0] N_SUM = SUM_W'(NUM_BLOCKS);

    // reciprocal of the block size, exact for every SUM_W-bit dividend
    localparam int DIV_L = $clog2(BLOCK_BYTES);
    localparam int DIV_S = SUM_W + DIV_L;
    localparam int DIV_W = SUM_W + 14;
    localparam logic [DIV_W-1:0] DIV_M =
        DIV_W'(((longint'(1) << DIV_S) + longint'(BLOCK_BYTES) - 1) / longint'(BLOCK_BYTES));

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_FLUSH  = 4'b1000
    } t_state;

    t_state    r_state;
    t_state    n_state;
    t_ffa_wave r_inj;        // record entering the first cell
    t_ffa_wave n_inj;
    logic      r_status;
    logic      n_status;
    logic [WAVE_W-1:0] r_start;
    logic [WAVE_W-1:0] n_start;
    t_ffa_rsp  r_res;        // finished result waiting for the output register
    t_ffa_rsp  n_res;
    logic      r_out_valid;
    logic      n_out_valid;
    t_ffa_rsp  r_out;
    t_ffa_rsp  n_out;

    t_ffa_wave w_wave [NUM_BLOCKS+1];
    t_ffa_wave w_exit;

    logic              w_in_xfer;
    logic              w_out_free;
    logic [SUM_W-1:0]  w_need_full;
    logic [SUM_W-1:0]  w_lo_full;
    logic [SUM_W-1:0]  w_end_full;
    logic [SUM_W-1:0]  w_lo_clamp;
    logic [SUM_W-1:0]  w_end_clamp;
    logic              w_need_ok;
    logic [PROD_W-1:0] w_granted;

    // byte count to block count: multiply by the reciprocal and shift
    function automatic logic [SUM_W-1:0] blk_div(input logic [SUM_W-1:0] x);
        logic [DIV_W-1:0] prod;
        prod = DIV_W'(x) * DIV_M;
        return SUM_W'(prod >> DIV_S);
    endfunction

    // row of cells, each owning one map bit
    assign w_wave[0] = r_inj;
    genvar g;
    generate
        for (g = 0; g < NUM_BLOCKS; g++) begin : g_cell
            ffa_cell #(
                .CELL_IDX(g)
            ) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_wave (w_wave[g]),
                .o_wave (w_wave[g+1])
            );
        end
    endgenerate
    assign w_exit = w_wave[NUM_BLOCKS];

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // request decode: block count and free range, clamped at the map end
    always_comb begin
        w_need_full = blk_div(SUM_W'(i_in_req.request_bytes));
        w_lo_full   = blk_div(SUM_W'(i_in_req.region_address));
        w_end_full  = blk_div(SUM_W'(i_in_req.region_address)
                              + SUM_W'(i_in_req.request_bytes));
        w_lo_clamp  = (w_lo_full > N_SUM) ? N_SUM : w_lo_full;
        w_end_clamp = (w_end_full > N_SUM) ? N_SUM : w_end_full;
        w_need_ok   = (w_need_full != '0) && (w_need_full <= N_SUM);
    end

    assign w_granted = PROD_W'(r_start) * PROD_W'(BLOCK_BYTES);

    always_comb begin
        n_state     = r_state;
        n_inj       = r_inj;
        n_inj.valid = 1'b0;
        n_status    = r_status;
        n_start     = r_start;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_inj           = '0;
                    n_inj.valid     = 1'b1;
                    n_start         = '0;
                    if (i_in_req.req_type == REQ_ALLOC) begin
                        // search walk; a count of zero never matches
                        n_inj.upd  = 1'b0;
                        n_inj.need = w_need_ok ? WAVE_W'(w_need_full) : '0;
                        n_state    = ST_SEARCH;
                    end else begin
                        n_inj.upd     = 1'b1;
                        n_inj.set_val = 1'b0;
                        n_inj.lo      = WAVE_W'(w_lo_clamp);
                        n_inj.hi      = WAVE_W'(w_end_clamp);
                        n_status      = STATUS_OK;
                        n_state       = ST_UPDATE;
                    end
                end
            end
            ST_SEARCH: begin
                if (w_exit.valid) begin
                    n_inj         = '0;
                    n_inj.valid   = 1'b1;
                    n_inj.upd     = 1'b1;
                    n_inj.set_val = 1'b1;
                    if (w_exit.found) begin
                        n_inj.lo = w_exit.run_start;
                        n_inj.hi = w_exit.run_start + w_exit.need;
                        n_start  = w_exit.run_start;
                        n_status = STATUS_OK;
                    end else begin
                        n_status = STATUS_NOFIT;
                    end
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (w_exit.valid) begin
                    n_res.status          = r_status;
                    n_res.granted_address = w_granted[ADDR_W-1:0];
                    n_res.free_runs       = w_exit.runs[RUNS_W-1:0];
                    n_res.free_blocks     = w_exit.blocks[BLOCKS_W-1:0];
                    n_state               = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_inj.valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_inj       <= n_inj;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_start  <= n_start;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

// ----- hw/rtl/ffa_checker.sv -----
`timescale 1ns / 1ps

module ffa_checker
    import ffa_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input t_ffa_req i_in_req,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_ffa_rsp o_out_rsp
);

    // one request in flight: stall right after a transfer in
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while busy");

    // a result cannot appear in the cycle after a request is taken
    a_no_instant_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !(o_out_valid && i_out_stall)) |=> !$rose(o_out_valid))
        else $error("result too early");

    // a failed allocate grants no address
    a_nofit_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_rsp.status == STATUS_NOFIT)) |-> (o_out_rsp.granted_address == '0))
        else $error("address on failed allocate");

    // run count agrees with block count
    a_runs_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((7'(o_out_rsp.free_runs) <= o_out_rsp.free_blocks)
            && ((o_out_rsp.free_blocks == '0) == (o_out_rsp.free_runs == '0))))
        else $error("free runs inconsistent with free blocks");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_rsp)))
        else $error("stalled result changed");

endmodule

bind first_fit_bitmap_block_allocator_core ffa_checker u_ffa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_req   (i_in_req),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_rsp  (o_out_rsp)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import ffa_pkg::*;

    // geometry of the block as built with its default parameters
    localparam int NBLK    = DEF_NUM_BLOCKS;
    localparam int BBYTES  = DEF_BLOCK_BYTES;
    // an allocate walks the map twice, so allow a little over two walks
    localparam int DRAIN_CYCLES = 2 * NBLK + 16;
    // random requests per idling phase
    localparam int PHASE_ITEMS  = 345;

    // block map tracker: keeps its own used/free map, works out the
    // result of each accepted request and compares returned results
    class alloc_scoreboard;
        bit [NBLK-1:0] used_map;
        t_ffa_rsp      pending_rsp[$];
        // regions handed out, so the stimulus can free them again
        int            live_addr[$];
        int            live_blocks[$];
        int            errors;

        function new();
            used_map = '0;
            errors   = 0;
        endfunction

        // one line per mismatch, and count it
        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // apply an accepted request to the map and queue its result
        function void note_request(t_ffa_req req);
            t_ffa_rsp rsp;
            int       need;
            int       run_start;
            int       run_len;
            int       first_blk;
            int       end_blk;
            int       runs;
            int       blocks;
            bit       found;
            bit       prev_free;
            rsp       = '0;
            found     = 1'b0;
            run_start = 0;
            run_len   = 0;
            if (req.req_type == REQ_ALLOC) begin
                need = int'(req.request_bytes) / BBYTES;
                // first fit: lowest run of need free blocks
                if (need != 0 && need <= NBLK) begin
                    for (int i = 0; i < NBLK && !found; i++) begin
                        if (!used_map[i]) begin
                            if (run_len == 0) begin
                                run_start = i;
                            end
                            run_len++;
                            if (run_len == need) begin
                                found = 1'b1;
                            end
                        end else begin
                            run_len = 0;
                        end
                    end
                end
                if (found) begin
                    for (int i = run_start; i < run_start + need; i++) begin
                        used_map[i] = 1'b1;
                    end
                    rsp.status          = STATUS_OK;
                    rsp.granted_address = ADDR_W'(run_start * BBYTES);
                    live_addr.push_back(run_start * BBYTES);
                    live_blocks.push_back(need);
                    if (live_addr.size() > NBLK) begin
                        void'(live_addr.pop_front());
                        void'(live_blocks.pop_front());
                    end
                end else begin
                    rsp.status = STATUS_NOFIT;
                end
            end else begin
                // free clears [addr/16, (addr+bytes)/16), end clamped to the map
                first_blk = int'(req.region_address) / BBYTES;
                end_blk   = (int'(req.region_address) + int'(req.request_bytes)) / BBYTES;
                if (end_blk > NBLK) begin
                    end_blk = NBLK;
                end
                for (int i = first_blk; i < end_blk; i++) begin
                    used_map[i] = 1'b0;
                end
                rsp.status = STATUS_OK;
            end
            // count free runs and free blocks after the operation
            runs      = 0;
            blocks    = 0;
            prev_free = 1'b0;
            for (int i = 0; i < NBLK; i++) begin
                if (!used_map[i]) begin
                    blocks++;
                    if (!prev_free) begin
                        runs++;
                    end
                end
                prev_free = !used_map[i];
            end
            rsp.free_runs   = RUNS_W'(runs);
            rsp.free_blocks = BLOCKS_W'(blocks);
            pending_rsp.push_back(rsp);
        endfunction

        // compare a returned result with the oldest expected one
        task check_result(t_ffa_rsp got);
            t_ffa_rsp want;
            if (pending_rsp.size() == 0) begin
                report($sformatf("result with nothing expected: %h", got));
            end else begin
                want = pending_rsp.pop_front();
                if (got.status !== want.status) begin
                    report($sformatf("status got %0d want %0d", got.status, want.status));
                end
                if (got.granted_address !== want.granted_address) begin
                    report($sformatf("granted_address got %0d want %0d",
                                     got.granted_address, want.granted_address));
                end
                if (got.free_runs !== want.free_runs) begin
                    report($sformatf("free_runs got %0d want %0d",
                                     got.free_runs, want.free_runs));
                end
                if (got.free_blocks !== want.free_blocks) begin
                    report($sformatf("free_blocks got %0d want %0d",
                                     got.free_blocks, want.free_blocks));
                end
            end
        endtask
    endclass

    // every input known from time zero
    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_ffa_req i_in_req    = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_ffa_rsp o_out_rsp;

    // idling rates in percent of cycles, changed per phase
    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;

    alloc_scoreboard sb;

    first_fit_bitmap_block_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // result monitor: values read here are the ones sampled at this edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_rsp);
        end
    end

    function automatic t_ffa_req make_req(logic kind, int bytes, int addr);
        t_ffa_req r;
        r.req_type       = kind;
        r.request_bytes  = BYTES_W'(bytes);
        r.region_address = ADDR_W'(addr);
        return r;
    endfunction

    // drive one request until its transfer, note it, then maybe idle;
    // valid is left high when the next request follows straight away
    task automatic send_request(t_ffa_req req);
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(req);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // mostly allocate and free of handed-out regions, with some noise:
    // under-one-block sizes, whole-map sizes, random and clamped frees
    function automatic t_ffa_req random_request();
        t_ffa_req r;
        int       sel;
        int       cnt;
        int       idx;
        int       bytes;
        int       addr;
        addr = $urandom_range(0, 1023);
        sel  = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 55) begin
            if (sel < 70) begin
                cnt   = $urandom_range(1, 8);
                bytes = cnt * BBYTES + $urandom_range(0, BBYTES - 1);
            end else if (sel < 82) begin
                cnt   = $urandom_range(1, NBLK - 1);
                bytes = cnt * BBYTES + $urandom_range(0, BBYTES - 1);
            end else if (sel < 90) begin
                bytes = $urandom_range(0, BBYTES - 1);
            end else if (sel < 94) begin
                bytes = NBLK * BBYTES;
            end else begin
                bytes = $urandom_range(0, NBLK * BBYTES);
            end
            r = make_req(REQ_ALLOC, bytes, addr);
        end else begin
            if (sel < 70 && sb.live_addr.size() != 0) begin
                idx   = $urandom_range(0, sb.live_addr.size() - 1);
                addr  = sb.live_addr[idx];
                bytes = sb.live_blocks[idx] * BBYTES + $urandom_range(0, BBYTES - 1);
                sb.live_addr.delete(idx);
                sb.live_blocks.delete(idx);
            end else if (sel < 90) begin
                bytes = $urandom_range(0, 256);
            end else if (sel < 95) begin
                bytes = $urandom_range(0, NBLK * BBYTES);
            end else begin
                // sweep that clears the whole map
                addr  = $urandom_range(0, BBYTES - 1);
                bytes = NBLK * BBYTES;
            end
            r = make_req(REQ_FREE, bytes, addr);
        end
        return r;
    endfunction

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, run with light sender idling and frequent receiver stalls
        sender_idle_pct    = 10;
        receiver_stall_pct = 63;
        // zero-block allocates fail, address is ignored
        send_request(make_req(REQ_ALLOC, 0, 1023));
        send_request(make_req(REQ_ALLOC, 15, 0));
        send_request(make_req(REQ_ALLOC, 16, 0));
        // whole map while one block is used: no fit
        send_request(make_req(REQ_ALLOC, 1024, 0));
        send_request(make_req(REQ_FREE, 16, 0));
        // whole map fits, then the full map rejects everything
        send_request(make_req(REQ_ALLOC, 1024, 512));
        send_request(make_req(REQ_ALLOC, 16, 0));
        // free past the end is clamped at the last block
        send_request(make_req(REQ_FREE, 1024, 1023));
        // empty free ranges, then a three-block free that is refilled
        send_request(make_req(REQ_FREE, 0, 0));
        send_request(make_req(REQ_FREE, 15, 16));
        send_request(make_req(REQ_FREE, 48, 32));
        send_request(make_req(REQ_ALLOC, 48, 0));
        send_request(make_req(REQ_FREE, 1024, 0));
        // fragment the map and refill the holes first fit
        send_request(make_req(REQ_ALLOC, 32, 0));
        send_request(make_req(REQ_ALLOC, 32, 0));
        send_request(make_req(REQ_ALLOC, 47, 0));
        send_request(make_req(REQ_FREE, 31, 16));
        send_request(make_req(REQ_FREE, 32, 64));
        send_request(make_req(REQ_ALLOC, 16, 0));
        send_request(make_req(REQ_ALLOC, 48, 0));
        send_request(make_req(REQ_FREE, 16, 1008));
        send_request(make_req(REQ_FREE, 1024, 0));

        // random part in three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct    = 10;
                    receiver_stall_pct = 63;
                end
                1: begin
                    sender_idle_pct    = 63;
                    receiver_stall_pct = 10;
                end
                default: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            repeat (PHASE_ITEMS) send_request(random_request());
        end
        i_in_valid <= 1'b0;

        // drain the results still owed, then give the block time to misbehave
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- first_fit_bitmap_block_allocator_core.f -----
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_cell.sv
hw/rtl/first_fit_bitmap_block_allocator_core.sv
hw/rtl/ffa_checker.sv
bench/testbench.sv
